/* hdl/dabj_pkg.sv */
`default_nettype none
package dabj_pkg;

	// Build-time defaults for the top-level parameters
	localparam int TABLE_DEPTH_DEF   = 4096;
	localparam int PAYLOAD_WIDTH_DEF = 64;

	// Fixed field widths
	localparam int KEY_W      = 64;
	localparam int PAY_IN_W   = 64;
	localparam int SIZE_W     = 13;
	localparam int ROW_SLOT_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Slot field in the job carries the widest slot the depth range allows
	localparam int MAX_SLOT_W = 20;

	// Queue depths between the parts
	localparam int MID_DEPTH  = 2;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_LVL_W  = $clog2(OUT_DEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd1;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_BUILD    = 2'd1,
		CMD_FINALIZE = 2'd2,
		CMD_PROBE    = 2'd3
	} cmd_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		cmd_t                  cmd;
		logic                  hit;
		logic [MAX_SLOT_W-1:0] slot;
		logic [PAY_IN_W-1:0]   payload;
		logic                  payload_null;
		logic                  last;
	} job_t;

	// Result item waiting in the output queue
	typedef struct packed {
		logic                  accepted;
		logic                  matched;
		logic [ROW_SLOT_W-1:0] row_slot;
		logic [PAY_IN_W-1:0]   match_payload;
		logic                  match_payload_null;
		logic                  dense;
		logic                  last;
	} result_t;

endpackage
`default_nettype wire

/* hdl/direct_address_bitmap_join_top.sv */
// Build, probe and finalize items stream at one item per cycle while full stays low; a result
// passes range check, hand-off queue, memory read and output queue before it can be popped.
// A clear item returns its result at once, then walks every slot of the memory to clear it;
// later items wait in the hand-off queue meanwhile.
// After reset the same walk runs with full held high; key_offset resets to 0 and table_size to 4096.
`default_nettype none
module direct_address_bitmap_join_top #(
	parameter int TABLE_DEPTH   = dabj_pkg::TABLE_DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = dabj_pkg::PAYLOAD_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [1:0]                        command,
	input  wire logic [dabj_pkg::KEY_W-1:0]        key,
	input  wire logic                              key_null,
	input  wire logic [dabj_pkg::PAY_IN_W-1:0]     payload,
	input  wire logic                              payload_null,
	input  wire logic                              last_row,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dabj_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dabj_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   accepted,
	output logic                                   matched,
	output logic [dabj_pkg::ROW_SLOT_W-1:0]        row_slot,
	output logic [dabj_pkg::PAY_IN_W-1:0]          match_payload,
	output logic                                   match_payload_null,
	output logic                                   dense,
	output logic                                   last_row_out
);
	import dabj_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	job_t                   front_job;
	logic                   front_job_valid;
	logic                   mid_full;
	logic                   mid_empty;
	logic [$bits(job_t)-1:0] mid_rd_data;
	job_t                   back_job;
	logic                   back_pop;
	logic [CNT_W-1:0]       eff_size;
	logic                   init_busy;
	result_t                back_res;
	logic                   back_res_valid;
	logic [OUT_LVL_W-1:0]   out_level;
	logic [$bits(result_t)-1:0] out_rd_data;
	result_t                head;

	dabj_front #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.key          (key),
		.key_null     (key_null),
		.payload      (payload),
		.payload_null (payload_null),
		.last_row     (last_row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.hold         (init_busy),
		.job          (front_job),
		.job_valid    (front_job_valid),
		.job_ready    (!mid_full),
		.eff_size     (eff_size)
	);

	// Hand-off queue between classification and execution
	dabj_queue #(
		.WIDTH ($bits(job_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_job_valid && !mid_full),
		.wr_data (front_job),
		.full    (mid_full),
		.rd_en   (back_pop),
		.rd_data (mid_rd_data),
		.empty   (mid_empty),
		.level   ()
	);

	assign back_job = job_t'(mid_rd_data);

	dabj_back #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (!mid_empty),
		.job_pop   (back_pop),
		.eff_size  (eff_size),
		.out_level (out_level),
		.res       (back_res),
		.res_valid (back_res_valid),
		.init_busy (init_busy)
	);

	// Results wait here until popped
	dabj_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_res_valid),
		.wr_data (back_res),
		.full    (),
		.rd_en   (pop),
		.rd_data (out_rd_data),
		.empty   (empty),
		.level   (out_level)
	);

	assign head               = result_t'(out_rd_data);
	assign accepted           = head.accepted;
	assign matched            = head.matched;
	assign row_slot           = head.row_slot;
	assign match_payload      = head.match_payload;
	assign match_payload_null = head.match_payload_null;
	assign dense              = head.dense;
	assign last_row_out       = head.last;

endmodule
`default_nettype wire

/* hdl/dabj_queue.sv */
`default_nettype none
module dabj_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [WIDTH-1:0]             wr_data,
	output logic                              full,
	input  wire logic                         rd_en,
	output logic [WIDTH-1:0]                  rd_data,
	output logic                              empty,
	output logic [$clog2(DEPTH+1)-1:0]        level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = mem_q[rptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/dabj_front.sv */
`default_nettype none
module dabj_front #(
	parameter int TABLE_DEPTH   = 4096,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic [1:0]                            command,
	input  wire logic [dabj_pkg::KEY_W-1:0]            key,
	input  wire logic                                  key_null,
	input  wire logic [dabj_pkg::PAY_IN_W-1:0]         payload,
	input  wire logic                                  payload_null,
	input  wire logic                                  last_row,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [dabj_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dabj_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  hold,
	output dabj_pkg::job_t                             job,
	output logic                                       job_valid,
	input  wire logic                                  job_ready,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]           eff_size
);
	import dabj_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	logic [KEY_W-1:0]         key_offset_q;
	logic [SIZE_W-1:0]        table_size_q;

	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic                     key_null_s1;
	logic [KEY_W:0]           diff_s1;
	logic [PAYLOAD_WIDTH-1:0] payload_s1;
	logic                     payload_null_s1;
	logic                     last_s1;

	logic [KEY_W-1:0]         size_ext;
	logic [KEY_W-1:0]         eff_ext;
	logic [KEY_W:0]           diff;
	logic                     advance;
	logic                     take;
	logic                     in_range;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_offset_q <= '0;
			table_size_q <= SIZE_W'(4096);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_OFFSET: key_offset_q <= cfg_data;
				REG_TABLE_SIZE: table_size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the slot count to the table depth
	assign size_ext = KEY_W'(table_size_q);
	assign eff_ext  = (size_ext > KEY_W'(TABLE_DEPTH)) ? KEY_W'(TABLE_DEPTH) : size_ext;
	assign eff_size = CNT_W'(eff_ext);

	// Exact signed difference of key and offset
	assign diff = {key[KEY_W-1], key} - {key_offset_q[KEY_W-1], key_offset_q};

	// Accept when the stage is free or drains this cycle
	assign advance = !valid_s1 || job_ready;
	assign full    = !advance || hold;
	assign take    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1          <= cmd_t'(command);
			key_null_s1     <= key_null;
			diff_s1         <= diff;
			payload_s1      <= payload[PAYLOAD_WIDTH-1:0];
			payload_null_s1 <= payload_null;
			last_s1         <= last_row;
		end
	end

	// Range-check the slot and hand the classified item on
	assign in_range = !diff_s1[KEY_W] && (diff_s1[KEY_W-1:0] < eff_ext);

	assign job_valid        = valid_s1;
	assign job.cmd          = cmd_s1;
	assign job.hit          = !key_null_s1 && in_range;
	assign job.slot         = MAX_SLOT_W'(diff_s1[SLOT_W-1:0]);
	assign job.payload      = PAY_IN_W'(payload_s1);
	assign job.payload_null = payload_null_s1;
	assign job.last         = last_s1;

endmodule
`default_nettype wire

/* hdl/dabj_back.sv */
`default_nettype none
module dabj_back #(
	parameter int TABLE_DEPTH   = 4096,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dabj_pkg::job_t                      job,
	input  wire logic                                job_valid,
	output logic                                     job_pop,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    eff_size,
	input  wire logic [dabj_pkg::OUT_LVL_W-1:0]      out_level,
	output dabj_pkg::result_t                        res,
	output logic                                     res_valid,
	output logic                                     init_busy
);
	import dabj_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {
		ST_SWEEP,
		ST_RUN
	} state_t;

	state_t                   state_q;
	logic                     init_q;
	logic [SLOT_W-1:0]        sweep_addr_q;
	logic [CNT_W-1:0]         count_q;
	logic                     dense_q;

	logic                     valid_s2;
	cmd_t                     cmd_s2;
	logic                     hit_s2;
	logic [SLOT_W-1:0]        slot_s2;
	logic                     dense_s2;
	logic                     last_s2;
	logic [1:0]               meta_rd_s2;
	logic [PAYLOAD_WIDTH-1:0] pay_rd_s2;

	// Presence and null bit per slot, and the payload column
	logic [1:0]               meta_mem [TABLE_DEPTH];
	logic [PAYLOAD_WIDTH-1:0] pay_mem  [TABLE_DEPTH];

	logic [SLOT_W-1:0]        slot;
	logic                     sweeping;
	logic                     do_build;
	logic                     do_probe;
	logic                     meta_we;
	logic [SLOT_W-1:0]        meta_waddr;
	logic [1:0]               meta_wdata;
	logic                     pay_we;
	logic                     dense_next;
	logic                     matched;
	logic                     stored_null;

	assign slot     = job.slot[SLOT_W-1:0];
	assign sweeping = (state_q == ST_SWEEP);

	// Take an item only while the output queue has room for everything in flight
	assign job_pop  = !sweeping && job_valid
		&& ((32'(out_level) + 32'(valid_s2)) < OUT_DEPTH);
	assign do_build = job_pop && (job.cmd == CMD_BUILD) && job.hit;
	assign do_probe = job_pop && (job.cmd == CMD_PROBE);

	assign meta_we    = sweeping || do_build;
	assign meta_waddr = sweeping ? sweep_addr_q : slot;
	assign meta_wdata = sweeping ? 2'b00 : {1'b1, job.payload_null};
	assign pay_we     = do_build && !job.payload_null;

	assign init_busy = init_q;

	// Dense flag as it stands after the item
	always_comb begin
		case (job.cmd)
			CMD_CLEAR:    dense_next = 1'b0;
			CMD_FINALIZE: dense_next = (count_q == eff_size);
			default:      dense_next = dense_q;
		endcase
	end

	// Metadata memory: sweep clears, build sets, probe reads
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (do_probe) begin
			meta_rd_s2 <= meta_mem[slot];
		end
	end

	// Payload memory
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[slot] <= job.payload[PAYLOAD_WIDTH-1:0];
		end
		if (do_probe) begin
			pay_rd_s2 <= pay_mem[slot];
		end
	end

	// Sequencer: clearing sweep, table state and result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			init_q       <= 1'b1;
			sweep_addr_q <= '0;
			count_q      <= '0;
			dense_q      <= 1'b0;
			valid_s2     <= 1'b0;
			cmd_s2       <= CMD_CLEAR;
			hit_s2       <= 1'b0;
			slot_s2      <= '0;
			dense_s2     <= 1'b0;
			last_s2      <= 1'b0;
		end else begin
			valid_s2 <= job_pop;
			if (job_pop) begin
				cmd_s2   <= job.cmd;
				hit_s2   <= job.hit;
				slot_s2  <= slot;
				dense_s2 <= dense_next;
				last_s2  <= job.last;
				dense_q  <= dense_next;
			end
			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == SLOT_W'(TABLE_DEPTH - 1)) begin
						sweep_addr_q <= '0;
						state_q      <= ST_RUN;
						init_q       <= 1'b0;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (job_pop && (job.cmd == CMD_CLEAR)) begin
						count_q <= '0;
						state_q <= ST_SWEEP;
					end else if (do_build && (count_q != CNT_W'(TABLE_DEPTH))) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: state_q <= ST_SWEEP;
			endcase
		end
	end

	// Form the result from the item and the memory read
	assign matched     = (cmd_s2 == CMD_PROBE) && hit_s2 && (dense_s2 || meta_rd_s2[1]);
	assign stored_null = matched && meta_rd_s2[0];

	assign res_valid              = valid_s2;
	assign res.accepted           = (cmd_s2 == CMD_BUILD) && hit_s2;
	assign res.matched            = matched;
	assign res.row_slot           = (res.accepted || matched) ? ROW_SLOT_W'(slot_s2) : '0;
	assign res.match_payload      = (matched && !stored_null) ? PAY_IN_W'(pay_rd_s2) : '0;
	assign res.match_payload_null = stored_null;
	assign res.dense              = dense_s2;
	assign res.last               = last_s2;

endmodule
`default_nettype wire

/* sim/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dabj_pkg::*;

	localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PHASES  = 10;
	localparam int PRESSURE_PHASE = 3;
	localparam int ROWS_PER_PHASE = 114;

	// Register indexes that select no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;

	typedef struct {
		cmd_t        cmd;
		logic [63:0] key;
		logic        key_null;
		logic [63:0] payload;
		logic        payload_null;
		logic        last_row;
		result_t     want;
	} row_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  command = CMD_CLEAR;
	logic [63:0] key = '0;
	logic        key_null = 1'b0;
	logic [63:0] payload = '0;
	logic        payload_null = 1'b0;
	logic        last_row = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        accepted;
	logic        matched;
	logic [ROW_SLOT_W-1:0] row_slot;
	logic [63:0] match_payload;
	logic        match_payload_null;
	logic        dense;
	logic        last_row_out;

	direct_address_bitmap_join_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .key(key), .key_null(key_null),
		.payload(payload), .payload_null(payload_null), .last_row(last_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.empty(empty), .pop(pop),
		.accepted(accepted), .matched(matched), .row_slot(row_slot),
		.match_payload(match_payload), .match_payload_null(match_payload_null),
		.dense(dense), .last_row_out(last_row_out)
	);

	// Shadow of the join table
	bit          present_map [TABLE_DEPTH];
	bit          null_map [TABLE_DEPTH];
	bit          written [TABLE_DEPTH];
	logic [63:0] stored [TABLE_DEPTH];
	int          rows_built = 0;
	bit          dense_now = 1'b0;
	logic [63:0] offset_r = '0;
	logic [12:0] size_r = 13'd4096;

	row_t        rows_to_send [$];
	result_t     results_due [$];
	reg_write_t  reg_writes [$];
	logic [63:0] built_keys [$];
	row_t        cur_row;
	result_t     due_now;
	int          rows_queued = 0;
	int          mismatches = 0;
	int          idle_pct = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	bit          hold_wanted = 1'b0;
	bit          hold_used = 1'b0;
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_size();
		return (size_r > 13'd4096) ? TABLE_DEPTH : int'(size_r);
	endfunction

	// Slot of a key; no wraparound may bring a key into range
	function automatic bit slot_of(input logic [63:0] k, output logic [11:0] s);
		logic signed [64:0] d;
		d = $signed({k[63], k}) - $signed({offset_r[63], offset_r});
		s = d[11:0];
		return (d >= 0) && (d < eff_size());
	endfunction

	// Advance the shadow table by one item and return its result
	function automatic result_t table_step(input row_t r);
		result_t res;
		logic [11:0] s;
		bit hit;
		res = '0;
		s = '0;
		hit = 1'b0;
		if (r.cmd == CMD_BUILD || r.cmd == CMD_PROBE)
			hit = !r.key_null && slot_of(r.key, s);
		case (r.cmd)
			CMD_CLEAR: begin
				present_map = '{default: 1'b0};
				null_map = '{default: 1'b0};
				rows_built = 0;
				dense_now = 1'b0;
			end
			CMD_BUILD: begin
				if (hit) begin
					present_map[s] = 1'b1;
					null_map[s] = r.payload_null;
					if (!r.payload_null) begin
						stored[s] = r.payload;
						written[s] = 1'b1;
					end
					if (rows_built < TABLE_DEPTH)
						rows_built++;
					res.accepted = 1'b1;
					res.row_slot = s;
				end
			end
			CMD_FINALIZE: begin
				dense_now = (rows_built == eff_size());
			end
			default: begin
				if (hit && (dense_now || present_map[s])) begin
					res.matched = 1'b1;
					res.row_slot = s;
					res.match_payload_null = null_map[s];
					res.match_payload = null_map[s] ? '0 : stored[s];
				end
			end
		endcase
		res.dense = dense_now;
		res.last = r.last_row;
		return res;
	endfunction

	// Predict, then hand the item to the driver
	function automatic void queue_row(input row_t r);
		logic [11:0] s;
		// never read a slot whose payload was never written
		if (r.cmd == CMD_PROBE && dense_now && !r.key_null && slot_of(r.key, s))
			if (!null_map[s] && !written[s])
				r.key_null = 1'b1;
		r.want = table_step(r);
		if (r.cmd == CMD_CLEAR)
			built_keys.delete();
		else if (r.cmd == CMD_BUILD && r.want.accepted)
			built_keys.insert(built_keys.size(), r.key);
		rows_to_send.insert(rows_to_send.size(), r);
		rows_queued++;
	endfunction

	function automatic void queue_fixed(input cmd_t c, input logic [63:0] k, input logic kn,
			input logic [63:0] pay, input logic pn, input logic lr);
		row_t r;
		r.cmd = c;
		r.key = k;
		r.key_null = kn;
		r.payload = pay;
		r.payload_null = pn;
		r.last_row = lr;
		r.want = '0;
		queue_row(r);
	endfunction

	function automatic logic [63:0] pick_key();
		int unsigned sel;
		logic [63:0] k;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			k = offset_r + 64'($urandom_range(0, eff_size() + 2));
		else if (sel < 80)
			k = offset_r - 64'($urandom_range(1, 4));
		else if (sel < 92)
			k = {$urandom, $urandom};
		else begin
			case ($urandom_range(0, 3))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				2: k = '0;
				default: k = '1;
			endcase
		end
		return k;
	endfunction

	function automatic row_t make_row(input cmd_t c);
		row_t r;
		r.cmd = c;
		if (c == CMD_PROBE && built_keys.size() != 0 && $urandom_range(0, 9) < 4)
			r.key = built_keys[$urandom_range(0, built_keys.size() - 1)];
		else
			r.key = pick_key();
		r.key_null = ($urandom_range(0, 15) == 0);
		case ($urandom_range(0, 9))
			0: r.payload = '0;
			1: r.payload = '1;
			default: r.payload = {$urandom, $urandom};
		endcase
		r.payload_null = ($urandom_range(0, 5) == 0);
		r.last_row = ($urandom_range(0, 7) == 0);
		r.want = '0;
		return r;
	endfunction

	// One batch: optional clear, builds and probes, finalize.
	// Small tables sometimes get filled exactly so that finalize sets dense.
	function automatic void queue_batch(input int n);
		bit fill;
		int tries;
		int unsigned sel;
		row_t r;
		cmd_t c;
		fill = (eff_size() <= 64) && ($urandom_range(0, 9) < 4);
		if (fill || $urandom_range(0, 1) == 0)
			queue_row(make_row(CMD_CLEAR));
		if (fill) begin
			tries = 0;
			while (rows_built < eff_size() && tries < 4 * eff_size() + 8) begin
				r = make_row(CMD_BUILD);
				r.key_null = 1'b0;
				r.key = offset_r + 64'($urandom_range(0, eff_size() - 1));
				queue_row(r);
				tries++;
			end
			queue_row(make_row(CMD_FINALIZE));
		end
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (fill)
				c = (sel < 80) ? CMD_PROBE : (sel < 95) ? CMD_BUILD : CMD_FINALIZE;
			else
				c = (sel < 45) ? CMD_BUILD : (sel < 92) ? CMD_PROBE :
					(sel < 99) ? CMD_FINALIZE : CMD_CLEAR;
			queue_row(make_row(c));
		end
		queue_row(make_row(CMD_FINALIZE));
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Wait until every item is in and every result is out
	task automatic wait_idle();
		while (rows_to_send.size() != 0 || push || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the pending registers back to back, valid held high throughout
	task automatic flush_regs();
		reg_write_t w;
		cfg_valid <= 1'b1;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (w.idx == REG_KEY_OFFSET)
				offset_r = w.data;
			else if (w.idx == REG_TABLE_SIZE)
				size_r = w.data[12:0];
		end
		cfg_valid <= 1'b0;
	endtask

	// Driver: offer items from the pending queue, with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				results_due.insert(results_due.size(), cur_row.want);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (rows_to_send.size() != 0) begin
					cur_row = rows_to_send.pop_front();
					command <= cur_row.cmd;
					key <= cur_row.key;
					key_null <= cur_row.key_null;
					payload <= cur_row.payload;
					payload_null <= cur_row.payload_null;
					last_row <= cur_row.last_row;
					push <= 1'b1;
					if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
						gap_left = $urandom_range(1, 10);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: take results, compare with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					$display("%0t unexpected result: expected none, got slot %h", $time,
						row_slot);
					mismatches++;
				end else begin
					due_now = results_due.pop_front();
					check_field("accepted", 64'(due_now.accepted), 64'(accepted));
					check_field("matched", 64'(due_now.matched), 64'(matched));
					check_field("row_slot", 64'(due_now.row_slot), 64'(row_slot));
					check_field("match_payload", due_now.match_payload, match_payload);
					check_field("match_payload_null", 64'(due_now.match_payload_null),
						64'(match_payload_null));
					check_field("dense", 64'(due_now.dense), 64'(dense));
					check_field("last_row_out", 64'(due_now.last), 64'(last_row_out));
				end
			end
			if (hold_wanted && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 9);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int start;
		int unsigned sel;
		logic [63:0] off_word;
		logic [12:0] size_word;
		for (int i = 0; i < TABLE_DEPTH; i++)
			stored[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: table extremes, nulls, rebuilds, duplicates
		queue_fixed(CMD_PROBE, 64'd0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, 64'd0, 1'b0, '1, 1'b0, 1'b1);
		queue_fixed(CMD_BUILD, 64'd4095, 1'b0, 64'h1234, 1'b1, 1'b0);
		queue_fixed(CMD_BUILD, 64'd4096, 1'b0, '1, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, '1, 1'b0, '1, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, 64'd5, 1'b1, '1, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, 64'd0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, 64'd4095, 1'b0, '1, 1'b1, 1'b1);
		queue_fixed(CMD_PROBE, 64'd0, 1'b1, '0, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, 64'd4095, 1'b0, 64'h5a5a_a5a5_0f0f_f0f0, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, 64'd0, 1'b0, 64'hdead_beef_0000_0001, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, 64'd4095, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, 64'd0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_FINALIZE, '0, 1'b0, '0, 1'b0, 1'b1);
		queue_fixed(CMD_PROBE, KEY_MIN, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, KEY_MAX, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_CLEAR, '0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, 64'd0, 1'b0, '0, 1'b0, 1'b0);
		wait_idle();

		// Top offset, two slots: wraparound key, dense table
		reg_writes.insert(reg_writes.size(), '{REG_SPARE_2, {$urandom, $urandom}});
		reg_writes.insert(reg_writes.size(), '{REG_SPARE_3, {$urandom, $urandom}});
		reg_writes.insert(reg_writes.size(), '{REG_KEY_OFFSET, KEY_MAX});
		reg_writes.insert(reg_writes.size(),
			'{REG_TABLE_SIZE, {51'h7_ffff_ffff_ffff, 13'd2}});
		flush_regs();
		queue_fixed(CMD_BUILD, KEY_MAX, 1'b0, 64'h77, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, KEY_MIN, 1'b0, 64'h88, 1'b0, 1'b0);
		queue_fixed(CMD_BUILD, KEY_MAX, 1'b0, 64'h99, 1'b1, 1'b0);
		queue_fixed(CMD_FINALIZE, '0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, KEY_MAX, 1'b0, '0, 1'b0, 1'b1);
		queue_fixed(CMD_PROBE, KEY_MIN, 1'b0, '0, 1'b0, 1'b0);
		wait_idle();

		// Bottom offset, empty table: finalize drops dense, then sets it
		reg_writes.insert(reg_writes.size(), '{REG_KEY_OFFSET, KEY_MIN});
		reg_writes.insert(reg_writes.size(), '{REG_TABLE_SIZE, 64'd0});
		flush_regs();
		queue_fixed(CMD_FINALIZE, '0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_CLEAR, '0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_FINALIZE, '0, 1'b0, '0, 1'b0, 1'b0);
		queue_fixed(CMD_PROBE, KEY_MIN, 1'b0, '0, 1'b0, 1'b0);
		wait_idle();

		// Random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_pct = (p == RANDOM_PHASES - 1 || $urandom_range(0, 2) == 0) ? 0 :
				$urandom_range(5, 30);
			sel = (p < 5) ? p : $urandom_range(0, 4);
			case (sel)
				0: off_word = '0;
				1: off_word = KEY_MIN;
				2: off_word = KEY_MAX;
				3: off_word = {$urandom, $urandom};
				default: off_word = 64'($signed($urandom_range(0, 100)) - 50);
			endcase
			sel = (p < 8) ? p : $urandom_range(0, 7);
			case (sel)
				0: size_word = 13'd8191;
				1: size_word = 13'($urandom_range(1, 64));
				2: size_word = 13'd0;
				3: size_word = 13'd4096;
				4: size_word = 13'($urandom_range(0, 8191));
				5: size_word = 13'd1;
				6: size_word = 13'($urandom_range(4095, 4097));
				default: size_word = 13'($urandom_range(2, 16));
			endcase
			reg_writes.insert(reg_writes.size(), '{REG_KEY_OFFSET, off_word});
			reg_writes.insert(reg_writes.size(),
				'{REG_TABLE_SIZE, {51'($urandom), size_word}});
			flush_regs();
			if (p == PRESSURE_PHASE)
				hold_wanted = 1'b1;
			start = rows_queued;
			while (rows_queued - start < ROWS_PER_PHASE)
				queue_batch($urandom_range(8, 40));
			wait_idle();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* direct_address_bitmap_join_top.f */
hdl/dabj_pkg.sv
hdl/dabj_queue.sv
hdl/dabj_front.sv
hdl/dabj_back.sv
hdl/direct_address_bitmap_join_top.sv
sim/testbench.sv
